/* design/skf_pkg.sv */
// Package with types, widths and reset constants of the scalar Kalman filter.
package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int CIDX_W    = 2;
    localparam int DEN_W     = WORD_W + 1;
    localparam int REM_W     = WORD_W + 2;
    localparam int QUO_W     = GAIN_W + 1;
    localparam int MULA_W    = WORD_W + 1;
    localparam int MULB_W    = GAIN_W + 1;
    localparam int PROD_W    = MULA_W + MULB_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic        [WORD_W-1:0] t_uword;
    typedef logic signed [WORD_W-1:0] t_sword;
    typedef logic        [GAIN_W-1:0] t_gain;
    typedef logic        [CIDX_W-1:0] t_cidx;

    localparam t_uword NOISE_RST = t_uword'(((64'd1 << FRAC_BITS) + 64'd2) / 64'd5);
    localparam t_sword EST_RST   = t_sword'(64'd27 << FRAC_BITS);
    localparam t_uword ERR_RST   = t_uword'(64'd5 << FRAC_BITS);

    localparam logic [MULB_W-1:0] GAIN_ONE  = MULB_W'(1) << GAIN_W;
    localparam t_gain             GAIN_MAX  = '1;
    localparam logic [PROD_W-1:0] GAIN_HALF = PROD_W'(1) << (GAIN_W - 1);

    localparam t_cidx CFG_NOISE = 2'd0;
    localparam t_cidx CFG_EST   = 2'd1;
    localparam t_cidx CFG_ERR   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_EST,
        S_MUL_ERR,
        S_DONE
    } t_state;

endpackage

/* design/skf_if.sv */
// Handshake channels of the scalar Kalman filter: measurement, result and configuration.
interface skf_in_if;
    logic                  valid;
    logic                  ready;
    skf_pkg::t_sword       measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_out_if;
    logic                  valid;
    logic                  ready;
    skf_pkg::t_sword       estimate;
    skf_pkg::t_gain        gain;
    skf_pkg::t_uword       error_now;

    modport source (output valid, output estimate, output gain, output error_now, input ready);
    modport sink   (input valid, input estimate, input gain, input error_now, output ready);
endinterface

interface skf_cfg_if;
    logic                  valid;
    logic                  ready;
    skf_pkg::t_cidx        index;
    skf_pkg::t_uword       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/scalar_kalman_filter_top.sv */
// Scalar Kalman filter: one measurement in, one estimate/gain/error result out.
// A new measurement is taken only in idle, after the last one has passed the 17-step restoring divider
// for the gain and two passes through one shared 33x17 multiplier.
// Reset (synchronous, active low) loads the default noise, start estimate and start error.
// The configuration channel is always ready; a valid write to index 0, 1 or 2 reloads estimate and error.
module scalar_kalman_filter_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    skf_in_if.sink            i_meas,
    skf_out_if.source         o_result,
    skf_cfg_if.sink           i_cfg
);
    import skf_pkg::*;

    t_state r_state, n_state;

    t_uword r_noise;
    t_sword r_start_est;
    t_uword r_start_err;
    t_sword r_est;
    t_uword r_err;

    logic [CNT_W-1:0]  r_cnt;
    logic signed [DEN_W-1:0] r_diff;
    logic [DEN_W-1:0]  r_den;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    t_gain             r_gain;
    logic [MULA_W-1:0] r_mag;
    logic              r_neg;
    logic [PROD_W-1:0] r_prod;
    t_sword            r_est_new;

    logic   r_out_valid;
    t_sword r_out_est;
    t_gain  r_out_gain;
    t_uword r_out_err;

    logic in_ready;
    logic in_fire;
    logic cfg_fire;
    logic out_free;
    logic div_last;

    // Divider step signals.
    logic [REM_W-1:0]  div_shift;
    logic [REM_W:0]    div_trial;
    logic              div_take;
    logic [REM_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_quo;
    t_gain             gain_sat;

    // Shared multiplier.
    logic [MULA_W-1:0] mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    // Estimate and error update.
    logic [PROD_W-1:0]       est_round;
    logic [DEN_W-1:0]        step_mag;
    logic signed [WORD_W+2:0] est_wide;
    t_sword                  est_sat;
    logic [PROD_W-1:0]       err_round;
    logic [PROD_W-GAIN_W-1:0] err_shift;
    t_uword                  err_sat;

    assign cfg_fire = i_cfg.valid & i_cfg.ready;
    assign in_fire  = i_meas.valid & in_ready;
    assign out_free = ~r_out_valid | o_result.ready;
    assign div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    assign i_cfg.ready       = 1'b1;
    assign i_meas.ready      = in_ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.estimate = r_out_est;
    assign o_result.gain     = r_out_gain;
    assign o_result.error_now = r_out_err;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_meas.valid) n_state = S_DIV;
            S_DIV:     if (div_last) n_state = S_MUL_EST;
            S_MUL_EST: n_state = S_MUL_ERR;
            S_MUL_ERR: n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready = 1'b0;
        mul_a    = r_mag;
        mul_b    = {1'b0, r_gain};
        case (r_state)
            S_IDLE:    in_ready = 1'b1;
            S_MUL_EST: begin
                mul_a = r_mag;
                mul_b = {1'b0, r_gain};
            end
            S_MUL_ERR: begin
                mul_a = {1'b0, r_err};
                mul_b = GAIN_ONE - {1'b0, r_gain};
            end
            default:   in_ready = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring division step; the low numerator bit enters on the first step only.
    always_comb begin
        div_shift = {r_rem[REM_W-2:0], (r_cnt == '0) ? r_err[0] : 1'b0};
        div_trial = {1'b0, div_shift} - {2'b00, r_den};
        div_take  = ~div_trial[REM_W];
        n_rem     = div_take ? div_trial[REM_W-1:0] : div_shift;
        n_quo     = {r_quo[QUO_W-2:0], div_take};
        if (r_den == '0) begin
            gain_sat = '0;
        end else if (n_quo[QUO_W-1]) begin
            gain_sat = GAIN_MAX;
        end else begin
            gain_sat = n_quo[GAIN_W-1:0];
        end
    end

    // Rounded step toward the measurement, then signed saturation.
    always_comb begin
        est_round = r_prod + GAIN_HALF;
        step_mag  = est_round[GAIN_W +: DEN_W];
        if (r_neg) begin
            est_wide = (WORD_W+3)'(r_est) - $signed({2'b00, step_mag});
        end else begin
            est_wide = (WORD_W+3)'(r_est) + $signed({2'b00, step_mag});
        end
        if (est_wide > (WORD_W+3)'(signed'({1'b0, {(WORD_W-1){1'b1}}}))) begin
            est_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (est_wide < -(WORD_W+3)'(signed'(64'h80000000))) begin
            est_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            est_sat = est_wide[WORD_W-1:0];
        end
    end

    always_comb begin
        err_round = r_prod + GAIN_HALF;
        err_shift = err_round[PROD_W-1:GAIN_W];
        if (|err_shift[PROD_W-GAIN_W-1:WORD_W]) begin
            err_sat = '1;
        end else begin
            err_sat = err_shift[WORD_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_noise     <= NOISE_RST;
            r_start_est <= EST_RST;
            r_start_err <= ERR_RST;
            r_est       <= EST_RST;
            r_err       <= ERR_RST;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_fire) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (cfg_fire) begin
                case (i_cfg.index)
                    CFG_NOISE: begin
                        r_noise <= i_cfg.data;
                        r_est   <= r_start_est;
                        r_err   <= r_start_err;
                    end
                    CFG_EST: begin
                        r_start_est <= t_sword'(i_cfg.data);
                        r_est       <= t_sword'(i_cfg.data);
                        r_err       <= r_start_err;
                    end
                    CFG_ERR: begin
                        r_start_err <= i_cfg.data;
                        r_est       <= r_start_est;
                        r_err       <= i_cfg.data;
                    end
                    default: ;
                endcase
            end else if (r_state == S_DONE && out_free) begin
                r_est <= r_est_new;
                r_err <= err_sat;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_diff <= DEN_W'(i_meas.measurement) - DEN_W'(r_est);
                r_den  <= {1'b0, r_err} + {1'b0, r_noise};
                r_rem  <= {3'b000, r_err[WORD_W-1:1]};
                r_quo  <= '0;
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (div_last) begin
                    r_gain <= gain_sat;
                    r_neg  <= r_diff[DEN_W-1];
                    r_mag  <= r_diff[DEN_W-1] ? DEN_W'(-r_diff) : DEN_W'(r_diff);
                end
            end
            S_MUL_EST: begin
                r_prod <= mul_p;
            end
            S_MUL_ERR: begin
                r_est_new <= est_sat;
                r_prod    <= mul_p;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_est  <= r_est_new;
                    r_out_gain <= r_gain;
                    r_out_err  <= err_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

/* verif/skf_result_checker.sv */
// Checker that predicts each filter update from accepted measurements and compares the results.
`timescale 1ns / 100ps

module skf_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_flush,
    skf_in_if    meas,
    skf_out_if   result,
    skf_cfg_if   cfg,
    output int   o_pending,
    output int   o_fails,
    output int   o_checked
);
    import skf_pkg::*;

    localparam logic [63:0] ROUND_HALF = 64'd32768;
    localparam logic [63:0] UNIT_GAIN  = 64'd65536;
    localparam longint      SWORD_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      SWORD_MIN  = 64'shFFFF_FFFF_8000_0000;
    localparam int          PRINT_CAP  = 50;

    typedef struct packed {
        t_sword estimate;
        t_gain  gain;
        t_uword error_now;
    } t_filter_out;

    t_filter_out pending_updates[$];

    t_uword noise_r;
    t_sword start_x;
    t_uword start_p;
    t_sword est_x;
    t_uword err_p;
    int     fail_cnt = 0;
    int     checked_cnt = 0;

    assign o_fails   = fail_cnt;
    assign o_checked = checked_cnt;

    // One filter step: gain from P and R, then the rounded estimate move and the error shrink.
    function automatic t_filter_out filter_update(input t_uword p, input t_uword r,
                                                  input t_sword x, input t_sword z);
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] mag;
        logic [63:0] step_mag;
        logic [63:0] p_next;
        logic [63:0] gain_q;
        longint      xi;
        longint      zi;
        longint      d;
        longint      x_next;
        t_filter_out res;
        den    = 64'(p) + 64'(r);
        gain_q = '0;
        if (den != 0) begin
            quo    = (64'(p) << 16) / den;
            gain_q = (quo > 64'(GAIN_MAX)) ? 64'(GAIN_MAX) : quo;
        end
        xi = longint'(x);
        zi = longint'(z);
        d  = zi - xi;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        // Rounds the magnitude, so ties move away from zero in both directions.
        step_mag = (mag * gain_q + ROUND_HALF) >> 16;
        x_next = (d < 0) ? xi - longint'(step_mag) : xi + longint'(step_mag);
        if (x_next > SWORD_MAX) x_next = SWORD_MAX;
        if (x_next < SWORD_MIN) x_next = SWORD_MIN;
        p_next = (64'(p) * (UNIT_GAIN - gain_q) + ROUND_HALF) >> 16;
        if (p_next > 64'hFFFF_FFFF) p_next = 64'hFFFF_FFFF;
        res.estimate  = t_sword'(x_next[31:0]);
        res.gain      = t_gain'(gain_q[15:0]);
        res.error_now = t_uword'(p_next[31:0]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_cnt < PRINT_CAP)
            $display("MISMATCH at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_filter_out want;
        t_filter_out got;
        logic        reload;
        if (!i_rst_n) begin
            noise_r = NOISE_RST;
            start_x = EST_RST;
            start_p = ERR_RST;
            est_x   = EST_RST;
            err_p   = ERR_RST;
            pending_updates.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                reload = 1'b1;
                case (cfg.index)
                    CFG_NOISE: noise_r = cfg.data;
                    CFG_EST:   start_x = t_sword'(cfg.data);
                    CFG_ERR:   start_p = cfg.data;
                    default:   reload = 1'b0;
                endcase
                if (reload) begin
                    est_x = start_x;
                    err_p = start_p;
                end
            end
            // A result at this edge always belongs to an item accepted earlier.
            if (result.valid && result.ready) begin
                got = '{result.estimate, result.gain, result.error_now};
                if (pending_updates.size() == 0) begin
                    report_mismatch("result with no measurement waiting", 64'(got.estimate), '0);
                end else begin
                    want = pending_updates.pop_front();
                    if (got.estimate !== want.estimate)
                        report_mismatch("estimate", 64'(got.estimate), 64'(want.estimate));
                    if (got.gain !== want.gain)
                        report_mismatch("gain", 64'(got.gain), 64'(want.gain));
                    if (got.error_now !== want.error_now)
                        report_mismatch("error_now", 64'(got.error_now), 64'(want.error_now));
                end
                checked_cnt++;
            end
            if (meas.valid && meas.ready) begin
                want = filter_update(err_p, noise_r, est_x, meas.measurement);
                est_x = want.estimate;
                err_p = want.error_now;
                pending_updates.push_back(want);
            end
            if (i_flush) begin
                foreach (pending_updates[i])
                    report_mismatch("result never arrived", '0, 64'(pending_updates[i].estimate));
                pending_updates.delete();
            end
        end
        o_pending <= pending_updates.size();
    end

endmodule

/* verif/tb_scalar_kalman_filter_top.sv */
// Testbench top for the scalar Kalman filter: stimulus, backpressure and the final verdict.
`timescale 1ns / 100ps

module tb_scalar_kalman_filter_top;
    import skf_pkg::*;

    localparam int    HALF_PERIOD   = 6;
    localparam int    RESET_CYCLES  = 12;
    localparam int    RANDOM_ITEMS  = 2000;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    SETTLE_CYCLES = 40;
    localparam int    CYCLE_LIMIT   = 1_000_000;
    localparam int    HOLD_PHASE    = 3;
    localparam int    QUIET_FIRST   = 6;
    localparam int    QUIET_LAST    = 10;
    localparam t_cidx CFG_UNUSED    = 2'd3;
    localparam t_sword SWORD_MAX    = 32'sh7FFF_FFFF;
    localparam t_sword SWORD_MIN    = 32'sh8000_0000;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   flush;
    bit     idle_on;
    bit     hold_req;
    bit     hold_taken;
    int     hold_left = 0;
    int     pending;
    int     fails;
    int     checked;
    int     items_sent;
    int     settings_run;
    int     cycle_cnt;
    t_sword near_x;

    skf_in_if  meas_ch ();
    skf_out_if res_ch ();
    skf_cfg_if cfg_ch ();

    scalar_kalman_filter_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_meas   (meas_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    skf_result_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (flush),
        .meas      (meas_ch),
        .result    (res_ch),
        .cfg       (cfg_ch),
        .o_pending (pending),
        .o_fails   (fails),
        .o_checked (checked)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Caller lowers valid once the last write of a group has gone through.
    task automatic write_reg(input t_cidx idx, input t_uword val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_EST) near_x = t_sword'(val);
    endtask

    task automatic program_filter(input t_uword noise, input t_sword est, input t_uword err);
        write_reg(CFG_NOISE, noise);
        write_reg(CFG_EST, t_uword'(est));
        write_reg(CFG_ERR, err);
        cfg_ch.valid <= 1'b0;
        settings_run++;
    endtask

    task automatic send_meas(input t_sword z);
        int gap;
        gap = 0;
        if (idle_on) begin
            if ($urandom_range(99) < 3)
                gap = $urandom_range(1, 40);
            else
                while ($urandom_range(99) < 16) gap++;
        end
        if (gap > 0) begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        meas_ch.valid       <= 1'b1;
        meas_ch.measurement <= z;
        do @(posedge i_clk); while (!meas_ch.ready);
        items_sent++;
    endtask

    // The pending count is registered, so look only after the next edge.
    task automatic wait_drained();
        meas_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_uword pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return t_uword'($urandom_range(1, 3));
            3:       return t_uword'($urandom_range(0, 32'h000F_FFFF));
            4:       return 32'h8000_0000;
            default: return t_uword'($urandom());
        endcase
    endfunction

    function automatic t_sword pick_meas();
        case ($urandom_range(9))
            0:       return SWORD_MAX;
            1:       return SWORD_MIN;
            2, 3, 4: return near_x + t_sword'(int'($urandom_range(0, 2000)) - 1000);
            default: return t_sword'($urandom());
        endcase
    endfunction

    task automatic random_phase(input int n);
        if ($urandom_range(1)) begin
            program_filter(pick_word(), t_sword'(pick_word()), pick_word());
        end else begin
            // A lone write still reloads the state, except at the unused index.
            write_reg(t_cidx'($urandom_range(3)), pick_word());
            cfg_ch.valid <= 1'b0;
            settings_run++;
        end
        repeat (n) send_meas(pick_meas());
        wait_drained();
    endtask

    // The receiver owns the long hold count; the stimulus only asks for it once.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < 16) begin
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Run exceeded %0d cycles with %0d results outstanding.", CYCLE_LIMIT, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int directed_sent;
        i_rst_n             <= 1'b0;
        flush               <= 1'b0;
        meas_ch.valid       <= 1'b0;
        meas_ch.measurement <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_NOISE;
        cfg_ch.data         <= '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        items_sent   = 0;
        settings_run = 1;
        near_x       = EST_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default settings straight out of reset, including the full-scale measurements.
        send_meas('0);
        send_meas(SWORD_MAX);
        send_meas(SWORD_MIN);
        send_meas(EST_RST);
        send_meas(-32'sd1);
        send_meas(32'sd1);
        wait_drained();

        // No measurement noise: the quotient reaches one and saturates.
        program_filter('0, '0, 32'h0001_0000);
        send_meas(SWORD_MAX);
        send_meas(SWORD_MIN);
        send_meas(32'sd12345);
        wait_drained();

        // Zero error and zero noise: the gain is forced to zero.
        program_filter('0, 32'sd12345, '0);
        send_meas(32'sd5);
        send_meas(SWORD_MIN);
        wait_drained();

        // Widest denominator, starting from the most negative estimate.
        program_filter('1, SWORD_MIN, '1);
        send_meas(SWORD_MAX);
        send_meas(SWORD_MIN);
        send_meas('0);
        wait_drained();

        program_filter(32'd1, SWORD_MAX, '1);
        send_meas(SWORD_MIN);
        send_meas(SWORD_MAX);
        wait_drained();

        // The unused index must change nothing, so the state carries on.
        write_reg(CFG_UNUSED, t_uword'($urandom()));
        cfg_ch.valid <= 1'b0;
        send_meas('0);
        send_meas(32'sd7);
        wait_drained();

        // Half gain on a unit innovation lands exactly on a rounding tie, both signs.
        program_filter(32'h0001_0000, '0, 32'h0001_0000);
        send_meas(32'sd1);
        wait_drained();
        program_filter(32'h0001_0000, '0, 32'h0001_0000);
        send_meas(-32'sd1);
        wait_drained();

        directed_sent = items_sent;
        phase = 0;
        while (items_sent - directed_sent < RANDOM_ITEMS) begin
            idle_on = !(phase >= QUIET_FIRST && phase < QUIET_LAST);
            if (phase == HOLD_PHASE) begin
                hold_req = 1'b1;
                random_phase(40);
            end else begin
                random_phase($urandom_range(1, 40));
            end
            phase++;
        end
        idle_on = 1'b1;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        flush <= 1'b1;
        @(posedge i_clk);
        flush <= 1'b0;
        @(posedge i_clk);

        $display("Sent %0d measurements under %0d filter settings; %0d results compared.",
                 items_sent, settings_run, checked);
        $display("Covered unit and zero gain, rounding ties, an unused index and a long stall.");
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches found.", fails);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
